[rtl/core/rcot_pkg.sv]
// Shared types and codes for the range copy offset tracker.
`timescale 1ns / 1ps

package rcot_pkg;

   // Item kinds carried in a request beat.
   typedef enum logic [1:0] {
      KIND_LOAD_SRC = 2'd0,
      KIND_LOAD_DST = 2'd1,
      KIND_COPY     = 2'd2,
      KIND_QUERY    = 2'd3
   } kind_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CROOT,
      ST_CRD,
      ST_CW0,
      ST_CW1,
      ST_CWP,
      ST_QRD,
      ST_QCHK,
      ST_WRD,
      ST_WOUT
   } state_type;

   // One request beat.
   typedef struct packed {
      kind_type           kind;
      logic [9:0]         position;
      logic [9:0]         source_start;
      logic [10:0]        copy_length;
      logic signed [31:0] load_value;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic signed [31:0] read_value;
      logic               came_from_copy;
   } rsp_type;

endpackage

[rtl/core/range_copy_offset_tracker.sv]
// Range copy tracker: word stores plus a lazy range-assign offset tree in RAM.
`timescale 1ns / 1ps

// A load writes its word store and leaves the block idle. A query walks the tree from
// the root toward a leaf, one level per QRD and QCHK pair, stops at the first tagged
// node, then reads a word (WRD) and gives one strobed response beat in its last state
// (WOUT). A copy tags the root in CROOT if it covers it, else visits each slot of its
// two boundary paths: CRD, CW0, CW1 and CWP for a partially covered node, CRD alone for
// a skipped slot. After synchronous reset every tree RAM node is cleared with busy
// high. Responses cannot be stalled by the receiver.
module range_copy_offset_tracker #(
   parameter int MEMORY_DEPTH = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rcot_pkg::req_type req_data,
   output logic             rsp_valid,
   output rcot_pkg::rsp_type rsp_data
);

   localparam int AW    = $clog2(MEMORY_DEPTH);
   localparam int NW    = AW + 1;
   localparam int NODES = 2 ** NW;
   localparam int OW    = AW + 1;
   localparam int TW    = OW + 1;
   localparam int XW    = ((AW > 11) ? AW : 11) + 2;
   localparam int LW    = $clog2(AW + 1) + 1;

   rcot_pkg::state_type state_ff, state_in;

   logic [XW-1:0] a_ff, b_ff;
   logic [OW-1:0] off_ff;
   logic [LW-1:0] lvl_ff;
   logic          side_ff;
   logic [NW-1:0] clr_ff;
   logic          qhas_ff;
   logic [OW-1:0] qoff_ff;
   logic          hit_ff;
   logic          oor_ff;

   logic [TW-1:0] node_mem_ff [NODES];
   logic [TW-1:0] node_q_ff;
   logic [31:0]   src_mem_ff [MEMORY_DEPTH];
   logic [31:0]   dst_mem_ff [MEMORY_DEPTH];
   logic [31:0]   src_q_ff, dst_q_ff;

   logic          accept;
   logic [XW-1:0] depth_x, pos_x, src_x, len_x, room_d, room_s, len_c, b_new;
   logic          pos_ok, src_ok, copy_ok;
   logic [OW-1:0] off_new;

   logic [LW-1:0] sh;
   logic [XW-1:0] cur_p, span, half, node_lo, node_hi, c0_hi, c1_lo;
   logic          node_in, c0_in, c1_in, dup, proceed, last_slot;
   logic [NW-1:0] node_addr, child0_addr, child1_addr;
   logic [TW-1:0] new_tag;

   logic          node_re, node_we;
   logic [NW-1:0] node_raddr, node_waddr;
   logic [TW-1:0] node_wdata;
   logic          word_re;
   logic signed [XW:0] s_pos;
   logic          s_ok;

   assign accept = start && !busy;

   // Decode a request beat: range checks and copy clipping.
   always_comb begin
      depth_x = XW'(MEMORY_DEPTH);
      pos_x   = XW'(req_data.position);
      src_x   = XW'(req_data.source_start);
      len_x   = XW'(req_data.copy_length);
      pos_ok  = pos_x < depth_x;
      src_ok  = src_x < depth_x;
      room_d  = depth_x - pos_x;
      room_s  = depth_x - src_x;
      len_c   = len_x;
      if (len_c > room_d) begin
         len_c = room_d;
      end
      if (len_c > room_s) begin
         len_c = room_s;
      end
      copy_ok = pos_ok && src_ok && (len_c != '0);
      b_new   = pos_x + len_c - XW'(1);
      off_new = OW'(src_x) - OW'(pos_x);
   end

   // Geometry of the current tree node and its two children.
   always_comb begin
      sh          = LW'(AW) - lvl_ff;
      cur_p       = side_ff ? b_ff : a_ff;
      span        = XW'(1) << sh;
      half        = span >> 1;
      node_lo     = (cur_p >> sh) << sh;
      node_hi     = node_lo + span - XW'(1);
      c0_hi       = node_lo + half - XW'(1);
      c1_lo       = node_lo + half;
      node_in     = (a_ff <= node_lo) && (node_hi <= b_ff);
      c0_in       = (a_ff <= node_lo) && (c0_hi <= b_ff);
      c1_in       = (a_ff <= c1_lo) && (node_hi <= b_ff);
      dup         = (a_ff >> sh) == (b_ff >> sh);
      proceed     = !node_in && !(side_ff && dup);
      last_slot   = side_ff && (lvl_ff == LW'(AW - 1));
      node_addr   = NW'((XW'(1) << lvl_ff) + (cur_p >> sh));
      child0_addr = {node_addr[NW-2:0], 1'b0};
      child1_addr = {node_addr[NW-2:0], 1'b1};
      new_tag     = {1'b1, off_ff};
   end

   // Source position for a covered query.
   always_comb begin
      s_pos = $signed({1'b0, a_ff}) + $signed({{(XW + 1 - OW){qoff_ff[OW-1]}}, qoff_ff});
      s_ok  = qhas_ff && !s_pos[XW] && ($unsigned(s_pos[XW-1:0]) < depth_x);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rcot_pkg::ST_CLEAR: begin
            if (&clr_ff) begin
               state_in = rcot_pkg::ST_IDLE;
            end
         end
         rcot_pkg::ST_IDLE: begin
            if (start) begin
               case (req_data.kind)
                  rcot_pkg::KIND_COPY: begin
                     if (copy_ok) begin
                        state_in = rcot_pkg::ST_CROOT;
                     end
                  end
                  rcot_pkg::KIND_QUERY: begin
                     state_in = pos_ok ? rcot_pkg::ST_QRD : rcot_pkg::ST_WOUT;
                  end
                  default: state_in = rcot_pkg::ST_IDLE;
               endcase
            end
         end
         rcot_pkg::ST_CROOT: begin
            state_in = node_in ? rcot_pkg::ST_IDLE : rcot_pkg::ST_CRD;
         end
         rcot_pkg::ST_CRD: begin
            if (proceed) begin
               state_in = rcot_pkg::ST_CW0;
            end else if (last_slot) begin
               state_in = rcot_pkg::ST_IDLE;
            end
         end
         rcot_pkg::ST_CW0: state_in = rcot_pkg::ST_CW1;
         rcot_pkg::ST_CW1: state_in = rcot_pkg::ST_CWP;
         rcot_pkg::ST_CWP: begin
            state_in = last_slot ? rcot_pkg::ST_IDLE : rcot_pkg::ST_CRD;
         end
         rcot_pkg::ST_QRD:  state_in = rcot_pkg::ST_QCHK;
         rcot_pkg::ST_QCHK: begin
            if (node_q_ff[TW-1] || (lvl_ff == LW'(AW))) begin
               state_in = rcot_pkg::ST_WRD;
            end else begin
               state_in = rcot_pkg::ST_QRD;
            end
         end
         rcot_pkg::ST_WRD:  state_in = rcot_pkg::ST_WOUT;
         rcot_pkg::ST_WOUT: state_in = rcot_pkg::ST_IDLE;
         default:           state_in = rcot_pkg::ST_IDLE;
      endcase
   end

   // Memory controls per state.
   always_comb begin
      node_re    = 1'b0;
      node_raddr = node_addr;
      node_we    = 1'b0;
      node_waddr = node_addr;
      node_wdata = '0;
      word_re    = 1'b0;
      case (state_ff)
         rcot_pkg::ST_CLEAR: begin
            node_we    = 1'b1;
            node_waddr = clr_ff;
         end
         rcot_pkg::ST_CROOT: begin
            node_we    = node_in;
            node_wdata = new_tag;
         end
         rcot_pkg::ST_CRD: begin
            node_re = proceed;
         end
         rcot_pkg::ST_CW0: begin
            node_we    = c0_in || node_q_ff[TW-1];
            node_waddr = child0_addr;
            node_wdata = c0_in ? new_tag : node_q_ff;
         end
         rcot_pkg::ST_CW1: begin
            node_we    = c1_in || node_q_ff[TW-1];
            node_waddr = child1_addr;
            node_wdata = c1_in ? new_tag : node_q_ff;
         end
         rcot_pkg::ST_CWP: begin
            node_we = 1'b1;
         end
         rcot_pkg::ST_QRD: begin
            node_re = 1'b1;
         end
         rcot_pkg::ST_WRD: begin
            word_re = 1'b1;
         end
         default: begin
            node_re = 1'b0;
         end
      endcase
   end

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcot_pkg::ST_CLEAR;
         clr_ff   <= '0;
         lvl_ff   <= '0;
         side_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == rcot_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + NW'(1);
         end
         if (accept) begin
            lvl_ff  <= '0;
            side_ff <= 1'b0;
         end else if (((state_ff == rcot_pkg::ST_CRD) && !proceed) ||
                      (state_ff == rcot_pkg::ST_CWP)) begin
            side_ff <= !side_ff;
            if (side_ff) begin
               lvl_ff <= lvl_ff + LW'(1);
            end
         end else if ((state_ff == rcot_pkg::ST_QCHK) && !node_q_ff[TW-1] &&
                      (lvl_ff != LW'(AW))) begin
            lvl_ff <= lvl_ff + LW'(1);
         end
      end
   end

   // Item payload capture.
   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff    <= pos_x;
         b_ff    <= b_new;
         off_ff  <= off_new;
         oor_ff  <= !pos_ok;
         qhas_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end
      if ((state_ff == rcot_pkg::ST_QCHK) && node_q_ff[TW-1]) begin
         qhas_ff <= 1'b1;
         qoff_ff <= node_q_ff[OW-1:0];
      end
      if (state_ff == rcot_pkg::ST_WRD) begin
         hit_ff <= s_ok;
      end
   end

   // Offset tree RAM.
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem_ff[node_waddr] <= node_wdata;
      end
      if (node_re) begin
         node_q_ff <= node_mem_ff[node_raddr];
      end
   end

   // Word stores.
   always_ff @(posedge clock) begin
      if (accept && pos_ok && (req_data.kind == rcot_pkg::KIND_LOAD_SRC)) begin
         src_mem_ff[pos_x[AW-1:0]] <= req_data.load_value;
      end
      if (word_re) begin
         src_q_ff <= src_mem_ff[s_pos[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pos_ok && (req_data.kind == rcot_pkg::KIND_LOAD_DST)) begin
         dst_mem_ff[pos_x[AW-1:0]] <= req_data.load_value;
      end
      if (word_re) begin
         dst_q_ff <= dst_mem_ff[a_ff[AW-1:0]];
      end
   end

   // Response beat.
   always_comb begin
      busy      = state_ff != rcot_pkg::ST_IDLE;
      rsp_valid = state_ff == rcot_pkg::ST_WOUT;
      rsp_data.came_from_copy = hit_ff && !oor_ff;
      if (oor_ff) begin
         rsp_data.read_value = '0;
      end else if (hit_ff) begin
         rsp_data.read_value = src_q_ff;
      end else begin
         rsp_data.read_value = dst_q_ff;
      end
   end

   // A response beat lasts one cycle and the block is then idle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("response beat longer than one cycle");

   // An accepted query keeps the block busy.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.kind == rcot_pkg::KIND_QUERY)) |=> busy)
      else $error("query accepted without going busy");

   // A query walk never writes the tree.
   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == rcot_pkg::ST_QRD) || (state_ff == rcot_pkg::ST_QCHK)) |-> !node_we)
      else $error("tree written during a query");

   // The level counter stays within the tree height.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (lvl_ff <= LW'(AW)))
      else $error("tree level out of range");

endmodule
